FILE: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

    localparam int NUM_SEMAPHORES = 10;
    localparam int MAX_WAITERS    = 16;

    localparam int SLOT_W     = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int QW         = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int LW         = $clog2(MAX_WAITERS + 1);
    localparam int WAIT_DEPTH = NUM_SEMAPHORES * MAX_WAITERS;
    localparam int WA_W       = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_WAIT    = 2'd1,
        OP_SIGNAL  = 2'd2,
        OP_DESTROY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSLOT = 2'd1,
        ST_BAD    = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    typedef struct packed {
        logic [7:0]         owner;
        logic signed [15:0] count;
        logic [QW-1:0]      head;
        logic [LW-1:0]      len;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    function automatic logic [WA_W-1:0] waiter_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [QW-1:0] pos);
        waiter_addr = WA_W'(slot) * WA_W'(MAX_WAITERS) + WA_W'(pos);
    endfunction

    function automatic logic [QW-1:0] pos_inc(input logic [QW-1:0] pos);
        pos_inc = (pos == QW'(MAX_WAITERS - 1)) ? QW'(0) : pos + QW'(1);
    endfunction

endpackage

FILE: rtl/core/counting_semaphore_table.sv
// channel   direction  handshake              payload
// request   in         start && !busy         i_opcode i_sem_index i_caller_id i_initial_value
// result    out        o_strobe, one cycle    o_status o_granted_index o_caller_blocked
//                                             o_woken_valid o_woken_thread o_last
//
// create, wait and signal without a wakeup end in S_EXEC; a signal that wakes a thread adds S_POP
// destroy: S_EXEC alone with an empty queue, else S_POP gives one result a cycle per waiter
// S_EXEC uses the registered slot memory read, S_POP the registered waiter memory read
// reset: i_rst_n low frees every slot, no clearing pass follows
// results are registered and shown for one cycle; the receiver cannot stall them
`timescale 1ns / 1ps

module counting_semaphore_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [3:0]         i_sem_index,
    input  logic [7:0]         i_caller_id,
    input  logic signed [15:0] i_initial_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [3:0]         o_granted_index,
    output logic               o_caller_blocked,
    output logic               o_woken_valid,
    output logic [7:0]         o_woken_thread,
    output logic               o_last
);

    import cst_pkg::*;

    t_state                    r_state, n_state;
    logic [NUM_SEMAPHORES-1:0] r_in_use, n_in_use;

    t_op                r_op;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_idx_ok;
    logic [7:0]         r_caller;
    logic signed [15:0] r_init;

    logic [QW-1:0] r_head, n_head;
    logic [LW-1:0] r_len, n_len;

    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [3:0]         r_granted, n_granted;
    logic               r_blocked, n_blocked;
    logic               r_woken_valid, n_woken_valid;
    logic [7:0]         r_woken_thread, n_woken_thread;
    logic               r_last, n_last;

    logic                accept;
    logic                idx_ok;
    logic                meta_we;
    logic [SLOT_W-1:0]   meta_waddr;
    t_meta               meta_wdata;
    logic [SLOT_W-1:0]   meta_raddr;
    logic [META_W-1:0]   meta_rdata;
    t_meta               m;
    logic                wt_we;
    logic [WA_W-1:0]     wt_waddr;
    logic [WA_W-1:0]     wt_raddr;
    logic [7:0]          wt_rdata;

    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic               ex_ok;
    logic signed [15:0] cnt_dec;
    logic signed [15:0] cnt_inc;
    logic               blocks;
    logic               q_full;
    logic               owner_ok;
    logic               wake;
    logic               drain;
    logic [QW:0]        tail_sum;
    logic [QW-1:0]      tail;
    logic               pop_last;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign idx_ok = ({1'b0, i_sem_index} < 5'(NUM_SEMAPHORES));
    assign meta_raddr = idx_ok ? i_sem_index[SLOT_W-1:0] : '0;
    assign m = t_meta'(meta_rdata);

    cst_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SEMAPHORES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    cst_ram #(
        .WIDTH (8),
        .DEPTH (WAIT_DEPTH)
    ) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (r_caller),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = NUM_SEMAPHORES - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        ex_ok    = r_idx_ok && r_in_use[r_slot];
        cnt_dec  = (m.count == 16'sh8000) ? m.count : m.count - 16'sd1;
        cnt_inc  = (m.count == 16'sh7fff) ? m.count : m.count + 16'sd1;
        blocks   = cnt_dec[15];
        q_full   = (m.len >= LW'(MAX_WAITERS));
        owner_ok = (m.owner == r_caller);
        wake     = ex_ok && (r_op == OP_SIGNAL) && (cnt_inc <= 16'sd0) && (m.len != '0);
        drain    = ex_ok && (r_op == OP_DESTROY) && owner_ok && (m.len != '0);
        tail_sum = {1'b0, m.head} + (QW+1)'(m.len);
        tail     = (tail_sum >= (QW+1)'(MAX_WAITERS))
                 ? QW'(tail_sum - (QW+1)'(MAX_WAITERS)) : QW'(tail_sum);
        pop_last = (r_len == LW'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (wake || drain) ? S_POP : S_IDLE;
            end
            S_POP: begin
                if (pop_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_in_use       = r_in_use;
        n_head         = r_head;
        n_len          = r_len;
        n_strobe       = 1'b0;
        n_status       = ST_OK;
        n_granted      = '0;
        n_blocked      = 1'b0;
        n_woken_valid  = 1'b0;
        n_woken_thread = '0;
        n_last         = 1'b1;
        meta_we        = 1'b0;
        meta_waddr     = r_slot;
        meta_wdata     = m;
        wt_we          = 1'b0;
        wt_waddr       = waiter_addr(r_slot, tail);
        wt_raddr       = waiter_addr(r_slot, m.head);

        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                n_strobe = 1'b1;
                if (r_op == OP_CREATE) begin
                    if (!free_found) begin
                        n_status = ST_NOSLOT;
                    end else begin
                        meta_we             = 1'b1;
                        meta_waddr          = free_slot;
                        meta_wdata.owner    = r_caller;
                        meta_wdata.count    = r_init;
                        meta_wdata.head     = '0;
                        meta_wdata.len      = '0;
                        n_in_use[free_slot] = 1'b1;
                        n_granted           = 4'(free_slot);
                    end
                end else if (!ex_ok) begin
                    n_status = ST_BAD;
                end else begin
                    case (r_op)
                        OP_WAIT: begin
                            if (blocks && q_full) begin
                                n_status = ST_FULL;
                            end else begin
                                meta_we          = 1'b1;
                                meta_wdata.count = cnt_dec;
                                if (blocks) begin
                                    meta_wdata.len = m.len + LW'(1);
                                    wt_we          = 1'b1;
                                    n_blocked      = 1'b1;
                                end
                            end
                        end
                        OP_SIGNAL: begin
                            meta_we          = 1'b1;
                            meta_wdata.count = cnt_inc;
                            if (wake) begin
                                meta_wdata.head = pos_inc(m.head);
                                meta_wdata.len  = m.len - LW'(1);
                                n_strobe        = 1'b0;
                                n_head          = pos_inc(m.head);
                                n_len           = LW'(1);
                            end
                        end
                        OP_DESTROY: begin
                            if (!owner_ok) begin
                                n_status = ST_BAD;
                            end else if (drain) begin
                                n_strobe = 1'b0;
                                n_head   = pos_inc(m.head);
                                n_len    = m.len;
                            end else begin
                                n_in_use[r_slot] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_strobe       = 1'b1;
                n_woken_valid  = 1'b1;
                n_woken_thread = wt_rdata;
                n_last         = pop_last;
                wt_raddr       = waiter_addr(r_slot, r_head);
                n_head         = pos_inc(r_head);
                n_len          = r_len - LW'(1);
                if (pop_last && (r_op == OP_DESTROY)) begin
                    n_in_use[r_slot] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_opcode);
            r_slot   <= meta_raddr;
            r_idx_ok <= idx_ok;
            r_caller <= i_caller_id;
            r_init   <= i_initial_value;
        end
        r_head         <= n_head;
        r_len          <= n_len;
        r_status       <= n_status;
        r_granted      <= n_granted;
        r_blocked      <= n_blocked;
        r_woken_valid  <= n_woken_valid;
        r_woken_thread <= n_woken_thread;
        r_last         <= n_last;
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_granted_index  = r_granted;
    assign o_caller_blocked = r_blocked;
    assign o_woken_valid    = r_woken_valid;
    assign o_woken_thread   = r_woken_thread;
    assign o_last           = r_last;

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a request in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result directly after final result");

    a_drain_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_woken_valid))
        else $error("waiter release interrupted");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_len != '0))
        else $error("pop from an empty wait queue");

    a_blocked_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_caller_blocked) |-> (o_last && !o_woken_valid && o_status == ST_OK))
        else $error("blocked result malformed");

endmodule

FILE: rtl/core/cst_ram.sv
`timescale 1ns / 1ps

module cst_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/tb_counting_semaphore_table.sv
`timescale 1ns / 1ps

module tb_counting_semaphore_table;
    import cst_pkg::*;

    typedef struct {
        t_op                op;
        logic [3:0]         idx;
        logic [7:0]         caller;
        logic signed [15:0] initv;
    } t_sem_req;

    typedef struct {
        t_status    status;
        logic [3:0] granted;
        logic       blocked;
        logic       woken_valid;
        logic [7:0] woken_thread;
        logic       last;
    } t_sem_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = 2'd0;
    logic [3:0]         i_sem_index = 4'd0;
    logic [7:0]         i_caller_id = 8'd0;
    logic signed [15:0] i_initial_value = 16'sd0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [3:0]         o_granted_index;
    logic               o_caller_blocked;
    logic               o_woken_valid;
    logic [7:0]         o_woken_thread;
    logic               o_last;

    counting_semaphore_table uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_sem_index      (i_sem_index),
        .i_caller_id      (i_caller_id),
        .i_initial_value  (i_initial_value),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_caller_blocked (o_caller_blocked),
        .o_woken_valid    (o_woken_valid),
        .o_woken_thread   (o_woken_thread),
        .o_last           (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // request queue and the planning view used to build mostly well-formed sequences
    t_sem_req    req_q[$];
    bit          plan_used[NUM_SEMAPHORES];
    logic [7:0]  plan_owner[NUM_SEMAPHORES];
    int          n_queued = 0;
    int          n_accepted = 0;

    // predicted table
    bit          sem_used[NUM_SEMAPHORES];
    logic [7:0]  sem_owner[NUM_SEMAPHORES];
    int          sem_count[NUM_SEMAPHORES];
    logic [7:0]  sem_waiters[NUM_SEMAPHORES][MAX_WAITERS];
    int          sem_head[NUM_SEMAPHORES];
    int          sem_len[NUM_SEMAPHORES];

    t_sem_result pending_results[$];

    int          n_errors = 0;
    int          n_checked = 0;
    int          n_blocked = 0;
    int          n_woken = 0;
    int          n_qfull = 0;
    int          n_noslot = 0;
    int          n_refused = 0;

    function automatic t_sem_result mk_result(t_status st, logic [3:0] gi, logic blk,
                                              logic wv, logic [7:0] wt, logic lst);
        t_sem_result r;
        r.status       = st;
        r.granted      = gi;
        r.blocked      = blk;
        r.woken_valid  = wv;
        r.woken_thread = wt;
        r.last         = lst;
        return r;
    endfunction

    function automatic logic [7:0] pop_waiter(int s);
        logic [7:0] t;
        t = sem_waiters[s][sem_head[s]];
        sem_head[s] = (sem_head[s] + 1) % MAX_WAITERS;
        sem_len[s]--;
        return t;
    endfunction

    task automatic apply_request(t_op op, logic [3:0] idx, logic [7:0] caller,
                                 logic signed [15:0] initv);
        int s;
        int c;
        int free_slot;
        bit ok;
        logic [7:0] t;
        s = idx;
        ok = (s < NUM_SEMAPHORES) && sem_used[(s < NUM_SEMAPHORES) ? s : 0];
        if (op == OP_CREATE) begin
            free_slot = -1;
            for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
                if (!sem_used[i]) free_slot = i;
            end
            if (free_slot < 0) begin
                n_noslot++;
                pending_results.push_back(mk_result(ST_NOSLOT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
            end else begin
                sem_used[free_slot]  = 1'b1;
                sem_owner[free_slot] = caller;
                sem_count[free_slot] = initv;
                sem_head[free_slot]  = 0;
                sem_len[free_slot]   = 0;
                pending_results.push_back(mk_result(ST_OK, 4'(free_slot), 1'b0, 1'b0,
                                                    8'd0, 1'b1));
            end
        end else if (!ok) begin
            n_refused++;
            pending_results.push_back(mk_result(ST_BAD, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
        end else if (op == OP_WAIT) begin
            c = (sem_count[s] > -32768) ? sem_count[s] - 1 : -32768;
            if (c < 0 && sem_len[s] >= MAX_WAITERS) begin
                n_qfull++;
                pending_results.push_back(mk_result(ST_FULL, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
            end else if (c < 0) begin
                sem_waiters[s][(sem_head[s] + sem_len[s]) % MAX_WAITERS] = caller;
                sem_len[s]++;
                sem_count[s] = c;
                n_blocked++;
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b1, 1'b0, 8'd0, 1'b1));
            end else begin
                sem_count[s] = c;
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
            end
        end else if (op == OP_SIGNAL) begin
            c = (sem_count[s] < 32767) ? sem_count[s] + 1 : 32767;
            sem_count[s] = c;
            if (c <= 0 && sem_len[s] > 0) begin
                t = pop_waiter(s);
                n_woken++;
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b0, 1'b1, t, 1'b1));
            end else begin
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
            end
        end else if (sem_owner[s] != caller) begin
            n_refused++;
            pending_results.push_back(mk_result(ST_BAD, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
        end else begin
            if (sem_len[s] == 0) begin
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 1'b1));
            end
            while (sem_len[s] > 0) begin
                t = pop_waiter(s);
                n_woken++;
                pending_results.push_back(mk_result(ST_OK, 4'd0, 1'b0, 1'b1, t,
                                                    sem_len[s] == 0));
            end
            sem_used[s]  = 1'b0;
            sem_owner[s] = 8'd0;
            sem_count[s] = 0;
            sem_head[s]  = 0;
            sem_len[s]   = 0;
        end
    endtask

    task automatic queue_request(t_op op, logic [3:0] idx, logic [7:0] caller,
                                 logic signed [15:0] initv);
        t_sem_req r;
        int free_slot;
        r.op     = op;
        r.idx    = idx;
        r.caller = caller;
        r.initv  = initv;
        if (op == OP_CREATE) begin
            free_slot = -1;
            for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
                if (!plan_used[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
                plan_used[free_slot]  = 1'b1;
                plan_owner[free_slot] = caller;
            end
        end else if (op == OP_DESTROY && idx < NUM_SEMAPHORES) begin
            if (plan_used[idx] && plan_owner[idx] == caller) plan_used[idx] = 1'b0;
        end
        req_q.push_back(r);
        n_queued++;
    endtask

    function automatic logic signed [15:0] pick_count();
        int k;
        k = $urandom_range(0, 9);
        if (k <= 5) return 16'(int'($urandom_range(0, 3)) - 1);
        if (k == 6) return 16'sh7FFF;
        if (k == 7) return 16'sh8000;
        return 16'($urandom);
    endfunction

    task automatic queue_random(bit fill);
        int live[$];
        int r;
        int s;
        int create_w;
        live = {};
        for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            if (plan_used[i]) live.push_back(i);
        end
        r = $urandom_range(0, 99);
        create_w = fill ? 60 : 12;
        if (r < 8) begin
            queue_request(t_op'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          8'($urandom), 16'($urandom));
        end else if (live.size() == 0 || r < 8 + create_w) begin
            queue_request(OP_CREATE, 4'($urandom_range(0, 15)), 8'($urandom), pick_count());
        end else begin
            s = live[$urandom_range(0, live.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < (fill ? 4 : 10)) begin
                if ($urandom_range(0, 99) < 85) begin
                    queue_request(OP_DESTROY, 4'(s), plan_owner[s], 16'($urandom));
                end else begin
                    queue_request(OP_DESTROY, 4'(s), plan_owner[s] ^ 8'($urandom_range(1, 255)),
                                  16'($urandom));
                end
            end else if (r < 55) begin
                queue_request(OP_WAIT, 4'(s), 8'($urandom), 16'($urandom));
            end else begin
                queue_request(OP_SIGNAL, 4'(s), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_sem_req r;
        bit idle_now;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_request(t_op'(i_opcode), i_sem_index, i_caller_id, i_initial_value);
                n_accepted++;
            end
            if (!start || !busy) begin
                idle_now = !(n_accepted >= 110 && n_accepted < 170)
                           && ($urandom_range(0, 99) < 10);
                if (req_q.size() > 0 && !idle_now) begin
                    r = req_q.pop_front();
                    i_opcode        <= r.op;
                    i_sem_index     <= r.idx;
                    i_caller_id     <= r.caller;
                    i_initial_value <= r.initv;
                    start           <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sem_result e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected result: status=%0d gi=%0d blk=%0d wv=%0d",
                             o_status, o_granted_index, o_caller_blocked, o_woken_valid,
                             " wt=%0d last=%0d", o_woken_thread, o_last);
                end
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (o_status !== e.status || o_granted_index !== e.granted
                        || o_caller_blocked !== e.blocked || o_woken_valid !== e.woken_valid
                        || o_woken_thread !== e.woken_thread || o_last !== e.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $write("mismatch on result %0d: exp st=%0d gi=%0d blk=%0d wv=%0d",
                               n_checked, e.status, e.granted, e.blocked, e.woken_valid);
                        $write(" wt=%0d last=%0d, ", e.woken_thread, e.last);
                        $write("got st=%0d gi=%0d blk=%0d wv=%0d",
                               o_status, o_granted_index, o_caller_blocked, o_woken_valid);
                        $display(" wt=%0d last=%0d", o_woken_thread, o_last);
                    end
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d requests accepted", n_accepted);
        $display("counting_semaphore_table test failed");
        $finish;
    end

    initial begin
        bit fill;
        // saturation at the top, then at the bottom with a wakeup
        queue_request(OP_CREATE, 4'd0, 8'h00, 16'sh7FFF);
        queue_request(OP_SIGNAL, 4'd0, 8'h33, 16'sd0);
        queue_request(OP_CREATE, 4'd0, 8'hFF, 16'sh8000);
        queue_request(OP_WAIT, 4'd1, 8'hAA, 16'sd0);
        queue_request(OP_SIGNAL, 4'd1, 8'h5A, 16'sd0);
        // refused slots and wrong owner, then a destroy by the owner
        queue_request(OP_WAIT, 4'd15, 8'h01, 16'sd0);
        queue_request(OP_SIGNAL, 4'd9, 8'h02, 16'sd0);
        queue_request(OP_DESTROY, 4'd10, 8'h00, 16'sd0);
        queue_request(OP_DESTROY, 4'd0, 8'h01, 16'sd0);
        queue_request(OP_DESTROY, 4'd0, 8'h00, 16'sd0);
        // fill a wait queue past its depth, then release all waiters
        for (int k = 0; k <= MAX_WAITERS; k++) begin
            queue_request(OP_WAIT, 4'd1, 8'(8'h10 + 13 * k), 16'sd0);
        end
        queue_request(OP_DESTROY, 4'd1, 8'hFF, 16'sd0);

        fill = 1'b0;
        for (int n = 0; n < 202; n++) begin
            if (n % 25 == 0) fill = ($urandom_range(0, 2) == 0);
            queue_random(fill);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_queued) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        n_errors += pending_results.size();
        $display("%0d requests, %0d results checked: %0d blocked waits, %0d wakeups",
                 n_accepted, n_checked, n_blocked, n_woken);
        $display("refusals: %0d table full, %0d bad slot or owner, %0d wait queue full",
                 n_noslot, n_refused, n_qfull);
        if (n_errors == 0) begin
            $display("counting_semaphore_table test passed");
        end else begin
            $display("%0d errors", n_errors);
            $display("counting_semaphore_table test failed");
        end
        $finish;
    end

endmodule

FILE: counting_semaphore_table.f
rtl/core/cst_pkg.sv
rtl/core/cst_ram.sv
rtl/core/counting_semaphore_table.sv
dv/tb_counting_semaphore_table.sv
